FILE: rtl/u8ent_pkg.sv
// ----------------------------------------------------------------------------
// u8ent_pkg
// Types, constants and entity table for the UTF-8 decoder with entity escape.
// ----------------------------------------------------------------------------
package u8ent_pkg;

    // One input transaction: one raw string byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    // One result transaction: one output character
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    localparam int ACC_W     = 36;
    localparam int LEFT_W    = 3;
    localparam int ENT_NUM   = 16;
    localparam int ENT_IDX_W = 4;
    localparam int ENT_MAX   = 8;
    localparam int POS_W     = 4;   // counts up to one entity plus one character

    // Byte classes
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    typedef logic [0:ENT_MAX-1][7:0] ent_text_t;

    // Code point matched by each entity (pairings kept as specified)
    function automatic logic [7:0] ent_code(input logic [ENT_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'd252;
            4'd1:    c = 8'd228;
            4'd2:    c = 8'd246;
            4'd3:    c = 8'd179;
            4'd4:    c = 8'd196;
            4'd5:    c = 8'd214;
            4'd6:    c = 8'd234;
            4'd7:    c = 8'd226;
            4'd8:    c = 8'd224;
            4'd9:    c = 8'd232;
            4'd10:   c = 8'd242;
            4'd11:   c = 8'd250;
            4'd12:   c = 8'd233;
            4'd13:   c = 8'd167;
            4'd14:   c = 8'd231;
            default: c = 8'd174;
        endcase
        return c;
    endfunction

    // Entity length in characters
    function automatic logic [POS_W-1:0] ent_len(input logic [ENT_IDX_W-1:0] idx);
        logic [POS_W-1:0] n;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd11: n = 4'd6;
            4'd6, 4'd7:                               n = 4'd7;
            default:                                  n = 4'd8;
        endcase
        return n;
    endfunction

    // Entity text, first character at index 0, padded with spaces
    function automatic ent_text_t ent_text(input logic [ENT_IDX_W-1:0] idx);
        ent_text_t t;
        case (idx)
            4'd0:    t = "&uuml;  ";
            4'd1:    t = "&auml;  ";
            4'd2:    t = "&ouml;  ";
            4'd3:    t = "&Uuml;  ";
            4'd4:    t = "&Auml;  ";
            4'd5:    t = "&Ouml;  ";
            4'd6:    t = "&ecirc; ";
            4'd7:    t = "&acirc; ";
            4'd8:    t = "&agrave;";
            4'd9:    t = "&egrave;";
            4'd10:   t = "&Egrave;";
            4'd11:   t = "&Euml;  ";
            4'd12:   t = "&eacute;";
            4'd13:   t = "&Eacute;";
            4'd14:   t = "&ccedil;";
            default: t = "&Ccedil;";
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/utf8_decode_html_entity_map.sv
// ----------------------------------------------------------------------------
// utf8_decode_html_entity_map
// Lenient UTF-8 decoder (1 to 6 byte sequences) with HTML entity escape.
// ----------------------------------------------------------------------------
// One string byte is taken per transaction on s_*, and the decoded characters
// leave one per transaction on m_*. The decoder state advances in the cycle a
// byte is accepted. The byte's results (up to nine characters: one entity of
// at most eight plus one plain character) are parked in a job register and
// shifted out one character per cycle through the output register while
// m_ready does not stall it. A byte that yields zero or one character
// therefore does not hold s_ready low unless m_ready stalls, so an ASCII
// stream runs at one byte per clock while m_ready stays high. A byte with more
// characters holds s_ready low while they drain or wait. The next byte is
// accepted in the same cycle that the last character of the current job moves
// to the output register. That move needs the output register empty, or its
// result taken by m_ready in that cycle. While a result waits there with
// m_ready low, hold both the job and the input. map_enable is written on
// cfg_* (always ready, reset value 1) and is sampled when a byte is accepted;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_decode_html_entity_map (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8ent_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8ent_pkg::out_item_t  m_data
);
    import u8ent_pkg::*;

    // Configuration
    logic map_enable_reg;

    // Decoder state
    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    // Emissions of the byte being accepted: e1 may be any value (entity
    // candidate), e2 is always a plain character
    logic [ACC_W-1:0] e1_val;
    logic             e1_has, e2_has;
    logic [7:0]       e2_byte;
    logic [ACC_W-1:0] start_val;
    logic [LEFT_W-1:0] start_need;
    logic             ent_hit;
    logic [ENT_IDX_W-1:0] ent_idx;
    logic [POS_W-1:0] e1_len;

    // Job register: the characters still to be sent for one byte
    logic                 job_valid_reg;
    logic [POS_W-1:0]     job_pos_reg;
    logic [POS_W-1:0]     job_total_reg;
    logic [POS_W-1:0]     job_e1_len_reg;
    logic                 job_hit_reg;
    logic [ENT_IDX_W-1:0] job_idx_reg;
    logic [7:0]           job_e1_byte_reg;
    logic [7:0]           job_e2_byte_reg;
    logic                 job_eos_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic       in_take, out_free, move, job_last;
    logic [7:0] cur_char;
    ent_text_t  cur_text;
    logic       b_cont;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Decode the incoming byte against the pending sequence
    // ------------------------------------------------------------------
    assign b_cont = (s_data.in_byte[7:6] == CONT_TAG);

    // Start value and continuation count of a byte opening a new sequence
    always_comb begin
        if (!s_data.in_byte[7]) begin
            start_val  = ACC_W'(s_data.in_byte);
            start_need = 3'd0;
        end else if (b_cont) begin
            start_val  = ACC_W'(s_data.in_byte[5:0]);
            start_need = 3'd5;
        end else if (!s_data.in_byte[5]) begin
            start_val  = ACC_W'(s_data.in_byte[4:0]);
            start_need = 3'd1;
        end else if (!s_data.in_byte[4]) begin
            start_val  = ACC_W'(s_data.in_byte[3:0]);
            start_need = 3'd2;
        end else if (!s_data.in_byte[3]) begin
            start_val  = ACC_W'(s_data.in_byte[2:0]);
            start_need = 3'd3;
        end else if (!s_data.in_byte[2]) begin
            start_val  = ACC_W'(s_data.in_byte[1:0]);
            start_need = 3'd4;
        end else begin
            start_val  = ACC_W'(s_data.in_byte[0]);
            start_need = 3'd5;
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        left_next = left_reg;
        e1_has    = 1'b0;
        e1_val    = '0;
        e2_has    = 1'b0;
        e2_byte   = s_data.in_byte;

        if (left_reg != '0 && b_cont) begin
            // Extend the pending sequence; emit once complete
            acc_next  = {acc_reg[ACC_W-7:0], s_data.in_byte[5:0] & CONT_MASK};
            left_next = left_reg - 3'd1;
            if (left_next == '0) begin
                e1_has   = 1'b1;
                e1_val   = acc_next;
                acc_next = '0;
            end
        end else begin
            // Flush an interrupted sequence, then start afresh
            if (left_reg != '0) begin
                e1_has = 1'b1;
                e1_val = acc_reg;
            end
            if (start_need == '0) begin
                e2_has    = 1'b1;
                e2_byte   = s_data.in_byte;
                acc_next  = '0;
                left_next = '0;
            end else begin
                acc_next  = start_val;
                left_next = start_need;
            end
        end

        // End of string: flush whatever is still pending
        if (s_data.end_of_string) begin
            if (left_next != '0) begin
                if (!e1_has) begin
                    e1_has = 1'b1;
                    e1_val = acc_next;
                end else begin
                    e2_has  = 1'b1;
                    e2_byte = acc_next[7:0];
                end
            end
            acc_next  = '0;
            left_next = '0;
        end
    end

    // Entity lookup on the first emission
    always_comb begin
        ent_hit = 1'b0;
        ent_idx = '0;
        for (int i = 0; i < ENT_NUM; i++) begin
            if (e1_val == ACC_W'(ent_code(ENT_IDX_W'(i)))) begin
                ent_hit = map_enable_reg;
                ent_idx = ENT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (!e1_has) begin
            e1_len = '0;
        end else if (ent_hit) begin
            e1_len = ent_len(ent_idx);
        end else begin
            e1_len = 4'd1;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: while the output register is free, drain the job one character a cycle
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign move     = job_valid_reg && out_free;
    assign job_last = (job_pos_reg == job_total_reg - 4'd1);
    assign s_ready  = !job_valid_reg || (move && job_last);
    assign in_take  = s_valid && s_ready;

    assign cur_text = ent_text(job_idx_reg);

    always_comb begin
        if (job_pos_reg < job_e1_len_reg) begin
            if (job_hit_reg) begin
                cur_char = cur_text[job_pos_reg[2:0]];
            end else begin
                cur_char = job_e1_byte_reg;
            end
        end else begin
            cur_char = job_e2_byte_reg;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            map_enable_reg <= cfg_data;
        end
    end

    // Decoder state and job register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            left_reg      <= '0;
            job_valid_reg <= 1'b0;
            job_pos_reg   <= '0;
        end else if (in_take) begin
            // Advance the decoder and load the new job
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            job_valid_reg <= e1_has || e2_has;
            job_pos_reg   <= '0;
        end else if (move) begin
            if (job_last) begin
                job_valid_reg <= 1'b0;
            end else begin
                job_pos_reg <= job_pos_reg + 4'd1;
            end
        end
    end

    // Job payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            job_total_reg   <= e1_len + POS_W'(e2_has);
            job_e1_len_reg  <= e1_len;
            job_hit_reg     <= ent_hit;
            job_idx_reg     <= ent_idx;
            job_e1_byte_reg <= e1_val[7:0];
            job_e2_byte_reg <= e2_byte;
            job_eos_reg     <= s_data.end_of_string;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_data_reg.out_byte    <= cur_char;
            m_data_reg.run_last    <= job_last;
            m_data_reg.string_done <= job_last && job_eos_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/u8ent_checker.sv
// ----------------------------------------------------------------------------
// u8ent_checker
// Port-level checks for the UTF-8 decoder with entity escape.
// ----------------------------------------------------------------------------
module u8ent_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input u8ent_pkg::in_item_t   s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input u8ent_pkg::out_item_t  m_data
);
    import u8ent_pkg::*;

    // Hold a stalled result transaction
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    // The final character of a string also closes its byte's run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_done |-> m_data.run_last)
        else $error("string_done without run_last");

    // A run of characters from one byte leaves without gaps
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("gap inside a run of characters");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind utf8_decode_html_entity_map u8ent_checker u_u8ent_checker (.*);
